@@ rtl/lbfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfc_pkg
// Types and constants shared by the LED blink-code fault display.
// ----------------------------------------------------------------------------
package lbfc_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned StepW    = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned AccumW   = 17;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned HeadW    = 2;

  localparam logic [CfgIdxW-1:0] CfgIdxBlinkStep = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxTick      = 1'b1;

  localparam logic [StepW-1:0] BlinkStepReset = 16'd500;
  localparam logic [TickW-1:0] TickReset      = 8'd4;

  localparam logic [HeadW-1:0] HeadSteps  = 2'd2;
  localparam logic [CodeW-1:0] TensWeight = 8'd10;
  localparam logic [CodeW-1:0] UnitWeight = 8'd1;

  typedef struct packed {
    logic [CodeW-1:0] error_code;
    logic [CodeW-1:0] alarm_code;
  } in_req_t;

  typedef struct packed {
    logic yellow_on;
    logic red_on;
  } out_req_t;

endpackage

@@ rtl/lbfc_accum.sv @@
// ----------------------------------------------------------------------------
// lbfc_accum
// Millisecond accumulator; flags a sequencer step once the period is reached.
// ----------------------------------------------------------------------------
module lbfc_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [lbfc_pkg::StepW-1:0] blink_step_ms_i,
  input  logic [lbfc_pkg::TickW-1:0] tick_ms_i,
  output logic                       step_o
);
  import lbfc_pkg::*;

  logic [AccumW-1:0] accum_q, accum_d;

  assign step_o = (accum_q >= {1'b0, blink_step_ms_i});

  always_comb begin
    accum_d = accum_q;
    if (adv_i) begin
      if (step_o) begin
        accum_d = '0;
      end else begin
        accum_d = accum_q + {{(AccumW-TickW){1'b0}}, tick_ms_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
    end else begin
      accum_q <= accum_d;
    end
  end

endmodule

@@ rtl/lbfc_seq.sv @@
// ----------------------------------------------------------------------------
// lbfc_seq
// Blink-code sequencer: head delay, tens on yellow, units on red.
// ----------------------------------------------------------------------------
module lbfc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               step_i,
  input  lbfc_pkg::in_req_t  req_i,
  output lbfc_pkg::out_req_t led_o
);
  import lbfc_pkg::*;

  logic [CodeW-1:0] digits_q, digits_d;
  logic [HeadW-1:0] head_q, head_d;
  logic             half_q, half_d;
  logic             yel_q, yel_d;
  logic             red_q, red_d;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] weight;

  // error beats alarm; zero means yellow steady
  assign code = (req_i.error_code != '0) ? req_i.error_code : req_i.alarm_code;
  assign weight = (digits_q >= TensWeight) ? TensWeight : UnitWeight;

  always_comb begin
    digits_d = digits_q;
    head_d   = head_q;
    half_d   = half_q;
    yel_d    = yel_q;
    red_d    = red_q;
    if (step_i) begin
      if (digits_q != '0) begin
        if (head_q != '0) begin
          head_d = head_q - 1'b1;
        end else begin
          if (digits_q >= TensWeight) begin
            yel_d = ~yel_q;
            red_d = 1'b0;
          end else begin
            yel_d = 1'b0;
            red_d = ~red_q;
          end
          half_d = ~half_q;
          // digit is used up on its second toggle
          if (half_q) begin
            digits_d = digits_q - weight;
          end
        end
      end else begin
        digits_d = code;
        half_d   = 1'b0;
        head_d   = HeadSteps;
        red_d    = 1'b0;
        yel_d    = (code == '0);
      end
    end
  end

  assign led_o.yellow_on = yel_d;
  assign led_o.red_on    = red_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      head_q   <= '0;
      half_q   <= 1'b0;
      yel_q    <= 1'b0;
      red_q    <= 1'b0;
    end else if (adv_i) begin
      digits_q <= digits_d;
      head_q   <= head_d;
      half_q   <= half_d;
      yel_q    <= yel_d;
      red_q    <= red_d;
    end
  end

endmodule

@@ rtl/led_blink_fault_code_unit.sv @@
// ----------------------------------------------------------------------------
// led_blink_fault_code_unit
// LED blink-code fault display, one LED result per tick request.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request is one tick carrying the error and alarm codes. The
//   block answers every tick with one output request holding the yellow and
//   red LED levels after that tick.
//   Latency: the result is valid the cycle after the tick is accepted.
//   Throughput: one tick per cycle unless out_stall_i holds the result; the
//   accumulator and sequencer go from their registers to the output register.
//   Stall: while the output request is held by out_stall_i, in_stall_o is
//   raised; once it is taken a new tick may be accepted in the same cycle.
//   Reset: accumulator and sequencer clear, both LEDs off, blink_step_ms
//   returns to 500 and tick_ms to 4, no output request is pending.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 blink_step_ms, 1 tick_ms); write only while no request is in flight.
// ----------------------------------------------------------------------------
module led_blink_fault_code_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lbfc_pkg::in_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lbfc_pkg::out_req_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lbfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lbfc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lbfc_pkg::*;

  logic [StepW-1:0] blink_step_q;
  logic [TickW-1:0] tick_q;
  logic             out_valid_q, out_valid_d;
  out_req_t         out_data_q;
  out_req_t         led_next;
  logic             accept;
  logic             step;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_step_q <= BlinkStepReset;
      tick_q       <= TickReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxBlinkStep: blink_step_q <= cfg_wdata_i[StepW-1:0];
        CfgIdxTick:      tick_q       <= cfg_wdata_i[TickW-1:0];
        default:         ;
      endcase
    end
  end

  lbfc_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (accept),
    .blink_step_ms_i (blink_step_q),
    .tick_ms_i       (tick_q),
    .step_o          (step)
  );

  lbfc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .step_i (step),
    .req_i  (in_data_i),
    .led_o  (led_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= led_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/lbfc_checker.sv @@
// ----------------------------------------------------------------------------
// lbfc_checker
// Port-level checks for the LED blink-code fault display.
// ----------------------------------------------------------------------------
module lbfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lbfc_pkg::out_req_t out_data_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);
  import lbfc_pkg::*;

  // a held result blocks new ticks
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result held");

  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result repeated");

  a_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.yellow_on && out_data_o.red_on))
    else $error("both LEDs lit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind led_blink_fault_code_unit lbfc_checker u_lbfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

@@ tb/led_blink_fault_code_unit_tb.sv @@
// ----------------------------------------------------------------------------
// led_blink_fault_code_unit_tb
// Self-checking bench for the LED blink-code fault display. Tick requests with
// error and alarm codes go in under random bursts and gaps. The output side
// stalls on its own pattern, with one long hold-off. A scoreboard class
// predicts the yellow and red levels of every tick and checks each result in
// order. Phases cover several step period and tick length settings, among
// them zero period, zero tick length, the largest values, and a period
// lowered below the running accumulator.
// ----------------------------------------------------------------------------
module led_blink_fault_code_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbfc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;
  localparam int RandomGoal = 900;

  typedef enum int {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_e;

  // Predicts LED levels tick by tick and holds them until the block answers.
  class led_code_scoreboard;
    logic [StepW-1:0]  blink_step;
    logic [TickW-1:0]  tick_len;
    logic [AccumW-1:0] accum;
    logic [CodeW-1:0]  digits;
    logic [HeadW-1:0]  head;
    logic              half;
    logic              yellow;
    logic              red;
    out_req_t          led_levels_q[$];
    int                failures;
    int                ticks_noted;
    int                results_checked;

    function new();
      blink_step      = BlinkStepReset;
      tick_len        = TickReset;
      accum           = '0;
      digits          = '0;
      head            = '0;
      half            = 1'b0;
      yellow          = 1'b0;
      red             = 1'b0;
      failures        = 0;
      ticks_noted     = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgIdxBlinkStep) begin
        blink_step = val[StepW-1:0];
      end else if (idx == CfgIdxTick) begin
        tick_len = val[TickW-1:0];
      end
    endfunction

    function void load_code(logic [CodeW-1:0] code);
      digits = code;
      half   = 1'b0;
      head   = HeadSteps;
      red    = 1'b0;
      yellow = (code == '0);
    endfunction

    // Second toggle of a digit uses it up.
    function void take_digit(logic [CodeW-1:0] weight);
      if (half) begin
        half   = 1'b0;
        digits = digits - weight;
      end else begin
        half = 1'b1;
      end
    endfunction

    function void note_tick(in_req_t req);
      out_req_t lv;
      ticks_noted++;
      if ({1'b0, accum} >= {2'b0, blink_step}) begin
        accum = '0;
        if (digits != '0) begin
          if (head != '0) begin
            head = head - 1'b1;
          end else if (digits >= TensWeight) begin
            yellow = ~yellow;
            red    = 1'b0;
            take_digit(TensWeight);
          end else begin
            yellow = 1'b0;
            red    = ~red;
            take_digit(UnitWeight);
          end
        end else if (req.error_code != '0) begin
          load_code(req.error_code);
        end else begin
          load_code(req.alarm_code);
        end
      end else begin
        accum = accum + AccumW'(tick_len);
      end
      lv.yellow_on = yellow;
      lv.red_on    = red;
      led_levels_q.push_back(lv);
    endfunction

    function void check_leds(out_req_t got);
      out_req_t want;
      if (led_levels_q.size() == 0) begin
        $error("LED result with none expected: yellow_on %0b red_on %0b",
               got.yellow_on, got.red_on);
        failures++;
        return;
      end
      want = led_levels_q.pop_front();
      results_checked++;
      if (got.yellow_on !== want.yellow_on) begin
        $error("yellow_on: expected %0b, actual %0b", want.yellow_on, got.yellow_on);
        failures++;
      end
      if (got.red_on !== want.red_on) begin
        $error("red_on: expected %0b, actual %0b", want.red_on, got.red_on);
        failures++;
      end
    endfunction

    function int pending();
      return led_levels_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_req_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_req_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  led_code_scoreboard sb = new();
  in_req_t held_codes    = '0;
  bit      long_hold_req = 1'b0;
  int      cycle_cnt     = 0;
  int      settings_cnt  = 0;

  // error_code in the high byte, alarm_code in the low byte
  logic [15:0] directed_codes [22] = '{
    16'h0000, 16'h0CFF, 16'hFF00, 16'h00FF, 16'hFFFF, 16'h0100, 16'h55AA,
    16'hAA55, 16'h8001, 16'h7F80, 16'h0000, 16'h0001, 16'h0A00, 16'h0A00,
    16'h0000, 16'h0000, 16'h0A01, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000,
    16'h0000
  };

  led_blink_fault_code_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // Both handshakes sampled with pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_leds(out_data_o);
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int          left;
    int          hold;
    mode = StallNone;
    left = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHalf:  out_stall_i <= ($urandom_range(0, 1) == 1);
          default:    out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic [CodeW-1:0] rand_code();
    if ($urandom_range(0, 3) == 0) return CodeW'($urandom_range(1, 255));
    return CodeW'($urandom_range(1, 29));
  endfunction

  // Codes mostly hold for a while like a real fault source; some ticks are noise.
  function automatic in_req_t pick_codes();
    in_req_t r;
    if ($urandom_range(0, 9) == 0) begin
      r.error_code = CodeW'($urandom_range(0, 255));
      r.alarm_code = CodeW'($urandom_range(0, 255));
      return r;
    end
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 4))
        0: held_codes = '0;
        1: held_codes = {8'h00, rand_code()};
        2: held_codes = {rand_code(), 8'h00};
        3: held_codes = {rand_code(), rand_code()};
        default: held_codes = 16'($urandom_range(0, 65535));
      endcase
    end
    return held_codes;
  endfunction

  task automatic send_tick(input in_req_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_ticks(input int count);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst--;
      send_tick(pick_codes());
    end
    in_valid_i <= 1'b0;
  endtask

  // Every tick has a result, so an empty scoreboard means the block is idle.
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Upper write bits of the tick register are junk on purpose.
  task automatic set_rates(input logic [StepW-1:0] step, input logic [TickW-1:0] tick);
    write_reg(CfgIdxBlinkStep, step);
    write_reg(CfgIdxTick, {8'($urandom_range(0, 255)), tick});
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  initial begin : stimulus
    logic [StepW-1:0] step;
    logic [TickW-1:0] tick;
    int               sent;
    int               n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: accumulator only grows
    send_ticks(8);
    wait_idle();

    // zero period steps every tick: no code, tens only, units only, priorities
    set_rates(16'd0, 8'd1);
    for (int i = 0; i < 22; i++) send_tick(in_req_t'(directed_codes[i]));
    in_valid_i <= 1'b0;
    wait_idle();

    // zero tick length holds the sequencer
    set_rates(16'd3, 8'd0);
    send_ticks(4);
    wait_idle();

    // largest period and tick, accumulator near its bound, long output hold-off
    set_rates(16'hFFFF, 8'hFF);
    long_hold_req = 1'b1;
    send_ticks(300);
    wait_idle();

    // period lowered below the running accumulator
    write_reg(CfgIdxBlinkStep, 16'd7);
    cfg_we_i <= 1'b0;
    settings_cnt++;
    send_ticks(40);
    wait_idle();

    set_rates(16'd1, 8'hFF);
    send_ticks(30);
    wait_idle();

    sent = 0;
    while (sent < RandomGoal) begin
      case ($urandom_range(0, 7))
        0:       step = '0;
        1:       step = 16'd1;
        6:       step = StepW'($urandom_range(7, 40));
        7:       step = 16'hFFFF;
        default: step = StepW'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       tick = '0;
        1:       tick = 8'hFF;
        default: tick = TickW'($urandom_range(1, 8));
      endcase
      set_rates(step, tick);
      n = $urandom_range(60, 120);
      send_ticks(n);
      sent += n;
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d LED results never arrived", sb.pending());
      sb.failures++;
    end
    $display("Ran %0d ticks under %0d rate settings; %0d LED results checked.",
             sb.ticks_noted, settings_cnt, sb.results_checked);
    $display("Failures: %0d, cycles: %0d", sb.failures, cycle_cnt);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
